/* rtl/srptg_pkg.sv */
// srptg_pkg: shared types and constants for the sync and ramped pulse train generator
// holds the register map, reset values, frame phase codes and the result word layout
// no dependencies
package srptg_pkg;

	// configuration port geometry
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int IDX_W      = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_PULSE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_STEP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_WIDTH         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_WIDTH        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WIDTH        = 3'd5;

	// register reset values
	localparam logic [15:0] RST_FIRST_PULSE_WIDTH = 16'd200;
	localparam logic [15:0] RST_WIDTH_STEP        = 16'd100;
	localparam logic [7:0]  RST_PULSE_COUNT       = 8'd17;
	localparam logic [15:0] RST_GAP_WIDTH         = 16'd100;
	localparam logic [15:0] RST_IDLE_WIDTH        = 16'd3500;
	localparam logic [15:0] RST_SYNC_WIDTH        = 16'd50;

	// frame phases
	typedef enum logic [2:0] {
		PH_OFF,
		PH_SYNC,
		PH_HIGH,
		PH_GAP,
		PH_IDLE
	} phase_t;

	// register file contents
	typedef struct packed {
		logic [15:0] first_pulse_width;
		logic [15:0] width_step;
		logic [7:0]  pulse_count;
		logic [15:0] gap_width;
		logic [15:0] idle_width;
		logic [15:0] sync_width;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic data_level;
		logic sync_level;
		logic enabled_flag;
		logic half_mode_flag;
	} res_t;

endpackage

/* rtl/srptg_cfg.sv */
// srptg_cfg: configuration register file with write-only port
// depends on srptg_pkg
module srptg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [srptg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srptg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output srptg_pkg::cfg_t                  cfg
);
	import srptg_pkg::*;

	cfg_t cfg_q;

	// register writes, ignored for unmapped indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_pulse_width <= RST_FIRST_PULSE_WIDTH;
			cfg_q.width_step        <= RST_WIDTH_STEP;
			cfg_q.pulse_count       <= RST_PULSE_COUNT;
			cfg_q.gap_width         <= RST_GAP_WIDTH;
			cfg_q.idle_width        <= RST_IDLE_WIDTH;
			cfg_q.sync_width        <= RST_SYNC_WIDTH;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_FIRST_PULSE_WIDTH: cfg_q.first_pulse_width <= cfg_wdata;
				REG_WIDTH_STEP:        cfg_q.width_step        <= cfg_wdata;
				REG_PULSE_COUNT:       cfg_q.pulse_count       <= cfg_wdata[7:0];
				REG_GAP_WIDTH:         cfg_q.gap_width         <= cfg_wdata;
				REG_IDLE_WIDTH:        cfg_q.idle_width        <= cfg_wdata;
				REG_SYNC_WIDTH:        cfg_q.sync_width        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/srptg_core.sv */
// srptg_core: frame sequencer state and the per-tick next-state logic
// button edge detection, zero-length phase skipping, phase counting and width ramp
// depends on srptg_pkg
module srptg_core #(
	parameter int WIDTH_COUNTER_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick,
	input  logic            ben,
	input  logic            bmo,
	input  srptg_pkg::cfg_t cfg,
	output srptg_pkg::res_t res
);
	import srptg_pkg::*;

	localparam int W = WIDTH_COUNTER_BITS;

	// sequencer state
	phase_t           phase_q;
	logic [W-1:0]     cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [W-1:0]     cw_q;
	logic             fhm_q;
	logic             en_q;
	logic             mode_q;
	logic             pben_q;
	logic             pbmo_q;

	// next state
	phase_t           phase_d;
	logic [W-1:0]     cnt_d;
	logic [IDX_W-1:0] idx_d;
	logic [W-1:0]     cw_d;
	logic             fhm_d;
	logic             en_d;
	logic             mode_d;

	// frame-start values and shared increments
	phase_t           ph0;
	logic [W-1:0]     cnt0;
	logic [IDX_W-1:0] idx0;
	logic [W-1:0]     cw0;
	logic [IDX_W-1:0] idx_inc;
	logic             inc_more;
	logic             idx0_more;
	logic [W:0]       cw_sum;
	logic [W-1:0]     cw_inc;
	logic [15:0]      gap_d;
	logic [15:0]      idle_d;
	logic [W-1:0]     dur;

	always_comb begin
		// toggles on rising button edges
		en_d   = en_q ^ (ben & ~pben_q);
		mode_d = mode_q ^ (bmo & ~pbmo_q);

		// frame start
		ph0   = phase_q;
		cnt0  = cnt_q;
		idx0  = idx_q;
		cw0   = cw_q;
		fhm_d = fhm_q;
		if (phase_q == PH_OFF && en_d) begin
			ph0   = PH_SYNC;
			cnt0  = '0;
			idx0  = '0;
			cw0   = W'(cfg.first_pulse_width);
			fhm_d = mode_d;
		end

		gap_d  = fhm_d ? {1'b0, cfg.gap_width[15:1]} : cfg.gap_width;
		idle_d = fhm_d ? {1'b0, cfg.idle_width[15:1]} : cfg.idle_width;

		// one saturating ramp adder, every gap exit works from the width held at the start of the tick
		idx_inc   = idx0 + IDX_W'(1);
		inc_more  = idx_inc < cfg.pulse_count;
		idx0_more = idx0 < cfg.pulse_count;
		cw_sum    = {1'b0, cw0} + (W+1)'(cfg.width_step);
		cw_inc    = cw_sum[W] ? {W{1'b1}} : cw_sum[W-1:0];

		// skip phases of zero length
		phase_d = ph0;
		cnt_d   = cnt0;
		idx_d   = idx0;
		cw_d    = cw0;
		if (phase_d == PH_SYNC && cfg.sync_width == '0) begin
			phase_d = idx0_more ? PH_HIGH : PH_IDLE;
			cnt_d   = '0;
		end
		if (phase_d == PH_HIGH && cw_d == '0) begin
			phase_d = PH_GAP;
			cnt_d   = '0;
		end
		if (phase_d == PH_GAP && gap_d == '0) begin
			idx_d   = idx_inc;
			cw_d    = cw_inc;
			phase_d = inc_more ? PH_HIGH : PH_IDLE;
			cnt_d   = '0;
		end
		// zero width with no ramp and no gap runs out the rest of the train
		if (phase_d == PH_HIGH && cw_d == '0) begin
			cnt_d = '0;
			if (gap_d == '0) begin
				idx_d   = cfg.pulse_count;
				phase_d = PH_IDLE;
			end else begin
				phase_d = PH_GAP;
			end
		end
		if (phase_d == PH_IDLE && idle_d == '0) begin
			phase_d = PH_OFF;
			cnt_d   = '0;
		end

		// line levels for this tick
		res.data_level     = (phase_d == PH_HIGH);
		res.sync_level     = (phase_d == PH_SYNC);
		res.enabled_flag   = en_d;
		res.half_mode_flag = mode_d;

		unique case (phase_d)
			PH_SYNC: dur = W'(cfg.sync_width);
			PH_HIGH: dur = cw_d;
			PH_GAP:  dur = W'(gap_d);
			PH_IDLE: dur = W'(idle_d);
			default: dur = '0;
		endcase

		// count the tick and leave the phase when its length is reached
		if (phase_d != PH_OFF) begin
			cnt_d = cnt_d + W'(1);
			if (cnt_d >= dur) begin
				cnt_d = '0;
				unique case (phase_d)
					PH_SYNC: phase_d = (idx_d < cfg.pulse_count) ? PH_HIGH : PH_IDLE;
					PH_HIGH: phase_d = PH_GAP;
					PH_GAP: begin
						idx_d   = idx_inc;
						cw_d    = cw_inc;
						phase_d = inc_more ? PH_HIGH : PH_IDLE;
					end
					default: phase_d = PH_OFF;
				endcase
			end
		end
	end

	// state update once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF;
			cnt_q   <= '0;
			idx_q   <= '0;
			cw_q    <= '0;
			fhm_q   <= 1'b0;
			en_q    <= 1'b0;
			mode_q  <= 1'b0;
			pben_q  <= 1'b0;
			pbmo_q  <= 1'b0;
		end else if (tick) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			cw_q    <= cw_d;
			fhm_q   <= fhm_d;
			en_q    <= en_d;
			mode_q  <= mode_d;
			pben_q  <= ben;
			pbmo_q  <= bmo;
		end
	end

endmodule

/* rtl/sync_and_ramped_pulse_train_generator.sv */
// a word accepted into the input register passes on to the result register when not stalled
// throughput: one word per cycle while out_stall stays low; the frame sequencer updates once per tick
// the input register stalls only while it holds a word and the result register is stalled
// reset (arst_n low, asynchronous): both stages empty, generator disabled, normal mode,
// frame sequencer off, registers back to their documented defaults
module sync_and_ramped_pulse_train_generator #(
	parameter int WIDTH_COUNTER_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_enable_level,
	input  logic                             button_mode_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             data_level,
	output logic                             sync_level,
	output logic                             enabled_flag,
	output logic                             half_mode_flag,
	input  logic                             cfg_wen,
	input  logic [srptg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srptg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import srptg_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1;
	logic ben_s1;
	logic bmo_s1;
	logic out_valid_q;
	logic out_free;
	logic advance;

	srptg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake between the input and result registers
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ben_s1 <= button_enable_level;
			bmo_s1 <= button_mode_level;
		end
	end

	srptg_core #(
		.WIDTH_COUNTER_BITS (WIDTH_COUNTER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance),
		.ben    (ben_s1),
		.bmo    (bmo_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_level     = res_q.data_level;
	assign sync_level     = res_q.sync_level;
	assign enabled_flag   = res_q.enabled_flag;
	assign half_mode_flag = res_q.half_mode_flag;

endmodule

/* rtl/srptg_checker.sv */
// srptg_checker: port-level checks for the pulse train generator, bound to the top level
// watches only the handshake and result ports of the top level
module srptg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic data_level,
	input logic sync_level,
	input logic enabled_flag,
	input logic half_mode_flag
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_level) && $stable(sync_level)
			&& $stable(enabled_flag) && $stable(half_mode_flag))
		else $error("stalled result word changed");

	// sync and data lines are never high together
	a_lines_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(data_level && sync_level))
		else $error("sync and data high in the same tick");

	// input side stalls only behind a stalled full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a result appearing on an empty output came from a word accepted through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without an accepted input word");

endmodule

bind sync_and_ramped_pulse_train_generator srptg_checker u_srptg_checker (.*);
